// ===== rtl/core/hrbe_pkg.sv =====
// hrbe_pkg: shared types, character codes and the hex digit decoder
// used by the hex record byte extractor modules; no dependencies
package hrbe_pkg;

	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [7:0] BYTE_LIMIT_RST = 8'd32;
	localparam logic [7:0] BYTE_CNT_MAX   = 8'hff;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_TRUNC = 3'd1,
		ERR_TYPE  = 3'd2,
		ERR_END   = 3'd3,
		ERR_SUM   = 3'd4
	} err_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       bvalid;
		err_t       err;
		logic       fin;
	} result_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

// ===== rtl/core/hrbe_parser.sv =====
// hrbe_parser: per-character record state machine and result decode
// depends on hrbe_pkg
module hrbe_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            char_in,
	input  logic                  eoi_in,
	input  logic                  text_mode,
	input  logic [7:0]            byte_limit,
	output hrbe_pkg::result_t     result
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_COUNT = 3'd1,
		PH_ADDR  = 3'd2,
		PH_TYPE  = 3'd3,
		PH_DATA  = 3'd4,
		PH_CSUM  = 3'd5,
		PH_SKIP  = 3'd6,
		PH_BITS  = 3'd7
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [2:0]      idx_q, idx_d;
	logic [8:0]      left_q, left_d;
	logic [7:0]      sum_q, sum_d;
	logic [7:0]      asm_q, asm_d;
	logic [7:0]      cnt_q, cnt_d;
	hrbe_pkg::err_t  err_q, err_d;
	logic            done_q, done_d;

	logic [3:0]      v;
	logic [7:0]      b;
	logic [7:0]      cnt_inc;
	logic [7:0]      bit_mask;
	logic [7:0]      bits_byte;
	logic            type_bad;

	assign v         = hrbe_pkg::hex_value(char_in);
	assign b         = asm_q | {4'd0, v};
	assign cnt_inc   = (cnt_q == hrbe_pkg::BYTE_CNT_MAX) ? cnt_q : cnt_q + 8'd1;
	assign bit_mask  = 8'h80 >> idx_q;
	assign bits_byte = asm_q | ((char_in == hrbe_pkg::CH_ONE) ? bit_mask : 8'd0);
	assign type_bad  = (cnt_q < byte_limit) ? (char_in != hrbe_pkg::CH_ZERO) :
		(idx_q[0] ? (char_in != hrbe_pkg::CH_ONE) : (char_in != hrbe_pkg::CH_ZERO));

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		left_d  = left_q;
		sum_d   = sum_q;
		asm_d   = asm_q;
		cnt_d   = cnt_q;
		err_d   = err_q;
		done_d  = done_q;
		result  = '0;
		if (err_q == hrbe_pkg::ERR_NONE && !done_q) begin
			if (eoi_in) begin
				result.valid = 1'b1;
				if (phase_q != PH_IDLE) begin
					err_d      = hrbe_pkg::ERR_TRUNC;
					phase_d    = PH_IDLE;
					result.err = hrbe_pkg::ERR_TRUNC;
				end else begin
					done_d     = 1'b1;
					result.fin = 1'b1;
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						if (text_mode) begin
							if (char_in == hrbe_pkg::CH_DASH) begin
								phase_d = PH_SKIP;
							end
						end else if (char_in == hrbe_pkg::CH_COLON) begin
							phase_d = PH_COUNT;
							idx_d   = 3'd0;
							sum_d   = 8'd0;
							asm_d   = 8'd0;
						end
					end
					PH_COUNT: begin
						if (idx_q == 3'd0) begin
							asm_d = {v, 4'd0};
							idx_d = 3'd1;
						end else begin
							sum_d   = b;
							left_d  = {b, 1'b0};
							idx_d   = 3'd0;
							phase_d = PH_ADDR;
						end
					end
					PH_ADDR: begin
						if (!idx_q[0]) begin
							asm_d = {v, 4'd0};
						end else begin
							sum_d = sum_q + b;
						end
						if (idx_q >= 3'd3) begin
							idx_d   = 3'd0;
							phase_d = PH_TYPE;
						end else begin
							idx_d = idx_q + 3'd1;
						end
					end
					PH_TYPE: begin
						if (type_bad) begin
							err_d        = (cnt_q < byte_limit) ? hrbe_pkg::ERR_TYPE
								: hrbe_pkg::ERR_END;
							phase_d      = PH_IDLE;
							result.valid = 1'b1;
							result.err   = err_d;
						end else if (idx_q == 3'd0) begin
							asm_d = {v, 4'd0};
							idx_d = 3'd1;
						end else begin
							sum_d   = sum_q + b;
							idx_d   = 3'd0;
							phase_d = (left_q != 9'd0) ? PH_DATA : PH_CSUM;
						end
					end
					PH_DATA: begin
						left_d = left_q - 9'd1;
						if (!left_q[0]) begin
							asm_d = {v, 4'd0};
						end else begin
							sum_d         = sum_q + b;
							cnt_d         = cnt_inc;
							result.valid  = 1'b1;
							result.bvalid = 1'b1;
							result.data   = b;
							if (left_q == 9'd1) begin
								phase_d = PH_CSUM;
								idx_d   = 3'd0;
							end
						end
					end
					PH_CSUM: begin
						if (idx_q == 3'd0) begin
							asm_d = {v, 4'd0};
							idx_d = 3'd1;
						end else begin
							idx_d   = 3'd0;
							phase_d = PH_IDLE;
							if ((sum_q + b) != 8'd0) begin
								err_d        = hrbe_pkg::ERR_SUM;
								result.valid = 1'b1;
								result.err   = hrbe_pkg::ERR_SUM;
							end
						end
					end
					PH_SKIP: begin
						phase_d = PH_BITS;
						idx_d   = 3'd0;
						asm_d   = 8'd0;
					end
					PH_BITS: begin
						asm_d = bits_byte;
						if (idx_q < 3'd7) begin
							idx_d = idx_q + 3'd1;
						end else begin
							idx_d         = 3'd0;
							phase_d       = PH_IDLE;
							cnt_d         = cnt_inc;
							result.valid  = 1'b1;
							result.bvalid = 1'b1;
							result.data   = bits_byte;
							if (cnt_inc >= byte_limit) begin
								done_d     = 1'b1;
								result.fin = 1'b1;
							end
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= 3'd0;
			left_q  <= 9'd0;
			sum_q   <= 8'd0;
			asm_q   <= 8'd0;
			cnt_q   <= 8'd0;
			err_q   <= hrbe_pkg::ERR_NONE;
			done_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
			asm_q   <= asm_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
			done_q  <= done_d;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != hrbe_pkg::ERR_NONE |=> $stable(err_q))
		else $error("latched error changed");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("finish flag dropped");

	a_cnt_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= $past(cnt_q))
		else $error("byte count decreased");

	a_silent_after_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != hrbe_pkg::ERR_NONE || done_q) |-> !result.valid)
		else $error("request produced after stop");

endmodule

// ===== rtl/core/hex_record_byte_extractor_unit.sv =====
// hex_record_byte_extractor_unit: top level with input register,
// configuration registers and result register; uses hrbe_pkg, hrbe_parser
// path: a character waits in the input register, its result in the result register
// throughput: one character per cycle unless in_stall; the parser state updates in one step
// input stalls only when a result-producing character meets a full, stalled result register
// reset: asynchronous, clears parse state, latched error and finish flag
module hex_record_byte_extractor_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         character,
	input  logic                               end_of_input,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         data_byte,
	output logic                               byte_valid,
	output logic [2:0]                         error_code,
	output logic                               finished,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hrbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                         cfg_data
);

	logic              text_mode_q;
	logic [7:0]        byte_limit_q;
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              eoi_s1;
	hrbe_pkg::result_t res;
	hrbe_pkg::result_t out_q;
	logic              out_valid_q;
	logic              out_free;
	logic              advance;
	logic              in_accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_mode_q  <= 1'b0;
			byte_limit_q <= hrbe_pkg::BYTE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hrbe_pkg::CFG_TEXT_MODE:  text_mode_q  <= cfg_data[0];
				hrbe_pkg::CFG_BYTE_LIMIT: byte_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && (!res.valid || out_free);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			char_s1 <= character;
			eoi_s1  <= end_of_input;
		end
	end

	hrbe_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.char_in    (char_s1),
		.eoi_in     (eoi_s1),
		.text_mode  (text_mode_q),
		.byte_limit (byte_limit_q),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_byte  = out_q.data;
	assign byte_valid = out_q.bvalid;
	assign error_code = out_q.err;
	assign finished   = out_q.fin;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(out_q))
		else $error("waiting request overwritten");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(char_s1) && $stable(eoi_s1))
		else $error("input stage lost a character");

	a_advance_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.valid) |-> out_free)
		else $error("request issued into full result register");

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for hex_record_byte_extractor_unit, hex record and dash text modes
// a predictor runs on every accepted request; results are checked in order at the output
// depends on hrbe_pkg and the unit's rtl only
`timescale 1ns / 100ps

module tb;

	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;

	typedef enum logic [2:0] {
		SEEK_MARK, GET_COUNT, GET_ADDR, GET_TYPE, GET_DATA, GET_CSUM, SKIP_ONE, GET_BITS
	} scan_t;

	typedef enum int {
		END_CLEAN, END_TRUNC, END_TYPE, END_RECORD, END_SUM, END_TEXT
	} wrap_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
	} req_t;

	typedef struct packed {
		logic [7:0]     data;
		logic           bvalid;
		hrbe_pkg::err_t err;
		logic           fin;
	} outcome_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [7:0]                     character = 8'd0;
	logic                           end_of_input = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [7:0]                     data_byte;
	logic                           byte_valid;
	logic [2:0]                     error_code;
	logic                           finished;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [hrbe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                     cfg_data = 8'd0;

	hex_record_byte_extractor_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.character(character),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.byte_valid(byte_valid),
		.error_code(error_code),
		.finished(finished),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// predictor state and its copy of the registers
	logic           cfg_text = 1'b0;
	logic [7:0]     cfg_limit = hrbe_pkg::BYTE_LIMIT_RST;
	scan_t          scan = SEEK_MARK;
	logic [2:0]     pos = 3'd0;
	logic [8:0]     left_digits = 9'd0;
	logic [7:0]     run_sum = 8'd0;
	logic [7:0]     shift_byte = 8'd0;
	logic [7:0]     byte_count = 8'd0;
	hrbe_pkg::err_t err_hold = hrbe_pkg::ERR_NONE;
	logic           done_hold = 1'b0;

	outcome_t outcome_q[$];
	req_t     char_queue[$];
	req_t     stage[$];

	int   n_pushed = 0;
	int   n_taken = 0;
	int   n_results = 0;
	int   fail_cnt = 0;
	int   gen_cnt = 0;
	int   send_wait = 0;
	int   recv_wait = 0;
	int   calm_left[2] = '{0, 0};
	logic in_taken = 1'b0;
	logic long_hold = 1'b0;

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c >= hrbe_pkg::CH_ZERO && c <= CH_NINE) return 4'(c - hrbe_pkg::CH_ZERO);
		if (c >= CH_LOW_A && c <= CH_LOW_F) return 4'(c - CH_LOW_A + 8'd10);
		if (c >= CH_UP_A && c <= CH_UP_F) return 4'(c - CH_UP_A + 8'd10);
		return 4'd0;
	endfunction

	task automatic emit(input logic [7:0] d, input logic bv, input hrbe_pkg::err_t e,
			input logic f);
		outcome_t r;
		r.data = d;
		r.bvalid = bv;
		r.err = e;
		r.fin = f;
		outcome_q.push_back(r);
	endtask

	task automatic trip(input hrbe_pkg::err_t code);
		err_hold = code;
		scan = SEEK_MARK;
		emit(8'd0, 1'b0, code, 1'b0);
	endtask

	function automatic void bump_count();
		if (byte_count != hrbe_pkg::BYTE_CNT_MAX) byte_count = byte_count + 8'd1;
	endfunction

	task automatic decode_char(input logic [7:0] ch, input logic eoi);
		logic [3:0] v;
		logic [7:0] b;
		v = nibble_of(ch);
		if (err_hold != hrbe_pkg::ERR_NONE || done_hold) return;
		if (eoi) begin
			if (scan != SEEK_MARK) begin
				trip(hrbe_pkg::ERR_TRUNC);
			end else begin
				done_hold = 1'b1;
				emit(8'd0, 1'b0, hrbe_pkg::ERR_NONE, 1'b1);
			end
			return;
		end
		case (scan)
			SEEK_MARK: begin
				if (cfg_text) begin
					if (ch == hrbe_pkg::CH_DASH) scan = SKIP_ONE;
				end else if (ch == hrbe_pkg::CH_COLON) begin
					scan = GET_COUNT;
					pos = 3'd0;
					run_sum = 8'd0;
					shift_byte = 8'd0;
				end
			end
			GET_COUNT: begin
				if (pos == 3'd0) begin
					shift_byte = {v, 4'h0};
					pos = 3'd1;
				end else begin
					b = shift_byte | {4'h0, v};
					run_sum = b;
					left_digits = {b, 1'b0};
					pos = 3'd0;
					scan = GET_ADDR;
				end
			end
			GET_ADDR: begin
				if (!pos[0]) shift_byte = {v, 4'h0};
				else run_sum = run_sum + (shift_byte | {4'h0, v});
				if (pos >= 3'd3) begin
					pos = 3'd0;
					scan = GET_TYPE;
				end else begin
					pos = pos + 3'd1;
				end
			end
			GET_TYPE: begin
				if (byte_count < cfg_limit) begin
					if (ch != hrbe_pkg::CH_ZERO) begin
						trip(hrbe_pkg::ERR_TYPE);
						return;
					end
				end else if (pos == 3'd0 ? ch != hrbe_pkg::CH_ZERO : ch != hrbe_pkg::CH_ONE) begin
					trip(hrbe_pkg::ERR_END);
					return;
				end
				if (pos == 3'd0) begin
					shift_byte = {v, 4'h0};
					pos = 3'd1;
				end else begin
					run_sum = run_sum + (shift_byte | {4'h0, v});
					pos = 3'd0;
					scan = (left_digits != 9'd0) ? GET_DATA : GET_CSUM;
				end
			end
			GET_DATA: begin
				if (!left_digits[0]) begin
					shift_byte = {v, 4'h0};
					left_digits = left_digits - 9'd1;
				end else begin
					b = shift_byte | {4'h0, v};
					run_sum = run_sum + b;
					bump_count();
					left_digits = left_digits - 9'd1;
					if (left_digits == 9'd0) begin
						scan = GET_CSUM;
						pos = 3'd0;
					end
					emit(b, 1'b1, hrbe_pkg::ERR_NONE, 1'b0);
				end
			end
			GET_CSUM: begin
				if (pos == 3'd0) begin
					shift_byte = {v, 4'h0};
					pos = 3'd1;
				end else begin
					b = shift_byte | {4'h0, v};
					pos = 3'd0;
					scan = SEEK_MARK;
					if (run_sum + b != 8'd0) trip(hrbe_pkg::ERR_SUM);
				end
			end
			SKIP_ONE: begin
				scan = GET_BITS;
				pos = 3'd0;
				shift_byte = 8'd0;
			end
			default: begin
				if (ch == hrbe_pkg::CH_ONE) shift_byte = shift_byte | (8'h80 >> pos);
				if (pos < 3'd7) begin
					pos = pos + 3'd1;
				end else begin
					pos = 3'd0;
					scan = SEEK_MARK;
					bump_count();
					if (byte_count >= cfg_limit) done_hold = 1'b1;
					emit(shift_byte, 1'b1, hrbe_pkg::ERR_NONE, byte_count >= cfg_limit);
				end
			end
		endcase
	endtask

	function automatic int draw_pause(input int side);
		if (calm_left[side] != 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 63) == 0) calm_left[side] = $urandom_range(20, 60);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
	endfunction

	task automatic note_fail(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10) $display("mismatch: %s", msg);
	endtask

	// request driver
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			decode_char(character, end_of_input);
			n_taken++;
		end
	end

	always @(negedge clk) begin
		req_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_wait != 0) begin
				send_wait <= send_wait - 1;
				in_valid <= 1'b0;
			end else if (char_queue.size() != 0) begin
				nxt = char_queue.pop_front();
				character <= nxt.ch;
				end_of_input <= nxt.eoi;
				in_valid <= 1'b1;
				send_wait <= draw_pause(0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.data = data_byte;
			got.bvalid = byte_valid;
			got.err = hrbe_pkg::err_t'(error_code);
			got.fin = finished;
			recv_wait <= draw_pause(1);
			n_results++;
			if (outcome_q.size() == 0) begin
				note_fail($sformatf("unexpected data=%h bv=%b err=%0d fin=%b",
					got.data, got.bvalid, got.err, got.fin));
			end else begin
				want = outcome_q.pop_front();
				if (got.data != want.data || got.bvalid != want.bvalid ||
						got.err != want.err || got.fin != want.fin)
					note_fail($sformatf("exp data=%h bv=%b err=%0d fin=%b, got data=%h bv=%b err=%0d fin=%b",
						want.data, want.bvalid, want.err, want.fin,
						got.data, got.bvalid, got.err, got.fin));
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= long_hold || recv_wait != 0;
		if (recv_wait != 0) recv_wait <= recv_wait - 1;
	end

	// long output hold-off so the unit backs up into its input
	initial begin
		while (!(n_results >= 40 && char_queue.size() > 50)) @(posedge clk);
		@(negedge clk);
		long_hold <= 1'b1;
		repeat (120) @(negedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#8_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [7:0] other_than(input logic [7:0] ch);
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == ch);
		return c;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] v);
		logic [7:0] c;
		if (v == 4'd0 && $urandom_range(0, 7) == 0) begin
			do c = 8'($urandom_range(0, 255));
			while (c == hrbe_pkg::CH_ZERO || nibble_of(c) != 4'd0);
		end else if (v < 4'd10) begin
			c = hrbe_pkg::CH_ZERO + 8'(v);
		end else begin
			c = (($urandom_range(0, 1) != 0) ? CH_LOW_A : CH_UP_A) + 8'(v) - 8'd10;
		end
		return c;
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic stage_char(input logic [7:0] ch);
		stage.push_back('{ch, 1'b0});
	endtask

	task automatic stage_end();
		stage.push_back('{8'($urandom_range(0, 255)), 1'b1});
	endtask

	task automatic stage_pair(input logic [7:0] b);
		stage_char(digit_char(b[7:4]));
		stage_char(digit_char(b[3:0]));
	endtask

	task automatic stage_noise(input int n);
		repeat (n) stage_char(other_than(cfg_text ? hrbe_pkg::CH_DASH : hrbe_pkg::CH_COLON));
	endtask

	task automatic stage_open(input int n);
		stage_char(hrbe_pkg::CH_COLON);
		repeat (n) stage_char(8'($urandom_range(0, 255)));
	endtask

	task automatic stage_bad_type(input logic [7:0] second);
		if ($urandom_range(0, 1) != 0) begin
			stage_char(other_than(hrbe_pkg::CH_ZERO));
		end else begin
			stage_char(hrbe_pkg::CH_ZERO);
			stage_char(other_than(second));
		end
	endtask

	task automatic build_hex_record(input int len, input logic [15:0] addr, input logic sum_ok);
		logic [7:0] sum;
		logic [7:0] d;
		logic [7:0] kind;
		kind = (gen_cnt < cfg_limit) ? 8'h00 : 8'h01;
		stage_char(hrbe_pkg::CH_COLON);
		stage_pair(8'(len));
		stage_pair(addr[15:8]);
		stage_pair(addr[7:0]);
		stage_char(hrbe_pkg::CH_ZERO);
		stage_char(kind[0] ? hrbe_pkg::CH_ONE : hrbe_pkg::CH_ZERO);
		sum = 8'(len) + addr[15:8] + addr[7:0] + kind;
		for (int k = 0; k < len; k++) begin
			d = rand_byte();
			sum = sum + d;
			stage_pair(d);
			if (gen_cnt < 255) gen_cnt++;
		end
		d = 8'd0 - sum;
		if (!sum_ok) d = d + 8'($urandom_range(1, 255));
		stage_pair(d);
	endtask

	task automatic build_text_record();
		stage_char(hrbe_pkg::CH_DASH);
		stage_char(8'($urandom_range(0, 255)));
		repeat (8) begin
			case ($urandom_range(0, 4))
				0, 1: stage_char(hrbe_pkg::CH_ONE);
				2, 3: stage_char(hrbe_pkg::CH_ZERO);
				default: stage_char(other_than(hrbe_pkg::CH_ONE));
			endcase
		end
		if (gen_cnt < 255) gen_cnt++;
	endtask

	task automatic release_stage(input int n);
		@(posedge clk);
		while (stage.size() != 0 && n != 0) begin
			char_queue.push_back(stage.pop_front());
			n_pushed++;
			n--;
		end
	endtask

	task automatic settle();
		while (n_taken != n_pushed || outcome_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [hrbe_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == hrbe_pkg::CFG_TEXT_MODE) cfg_text = val[0];
		else cfg_limit = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(input logic text, input logic [7:0] lim);
		write_reg(hrbe_pkg::CFG_TEXT_MODE, {7'd0, text});
		write_reg(hrbe_pkg::CFG_BYTE_LIMIT, lim);
	endtask

	initial begin
		wrap_t      last_step;
		int         cap;
		int         phase_no;
		int         base;
		int         len;
		logic       long_done;
		logic [7:0] lim;
		last_step = wrap_t'($urandom_range(0, 5));
		cap = (last_step == END_TYPE) ? 250 : 255;
		long_done = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: ignored marks, empty record, top address, last record split by a mode change
		stage_char(hrbe_pkg::CH_DASH);
		stage_char(8'h80);
		build_hex_record(0, 16'h0000, 1'b1);
		build_hex_record(1, 16'hffff, 1'b1);
		build_hex_record(3, 16'($urandom_range(0, 65535)), 1'b1);
		build_hex_record(2, 16'($urandom_range(0, 65535)), 1'b1);
		release_stage(stage.size() - 9);
		settle();
		set_mode(1'b1, 8'd255);
		release_stage(-1);

		repeat ($urandom_range(20, 35)) begin
			stage_noise($urandom_range(0, 2));
			build_text_record();
		end
		release_stage(-1);

		base = n_pushed;
		phase_no = 0;
		while (n_pushed - base < 800) begin
			settle();
			if (phase_no != 0 && $urandom_range(0, 3) == 0 && gen_cnt < 230) begin
				set_mode(1'b1, 8'd255);
				repeat ($urandom_range(5, 20)) begin
					stage_noise($urandom_range(0, 1));
					build_text_record();
				end
			end else begin
				case ($urandom_range(0, 2))
					0: lim = 8'd1;
					1: lim = 8'd255;
					default: lim = 8'($urandom_range(1, 255));
				endcase
				if (phase_no == 0) lim = 8'd1;
				set_mode(1'b0, lim);
				while (stage.size() < 150) begin
					stage_noise(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
					len = ($urandom_range(0, 39) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
					if (!long_done && cap == 255 && $urandom_range(0, 3) == 0) begin
						len = 255;
						long_done = 1'b1;
					end
					if (gen_cnt + len > cap) len = cap - gen_cnt;
					build_hex_record(len, 16'($urandom_range(0, 65535)), 1'b1);
				end
			end
			release_stage(-1);
			phase_no++;
		end

		settle();
		case (last_step)
			END_CLEAN: begin
				set_mode(1'b0, 8'd255);
				stage_noise(3);
				stage_end();
			end
			END_TRUNC: begin
				set_mode(1'b0, 8'd255);
				stage_open($urandom_range(0, 6));
				stage_end();
			end
			END_TYPE: begin
				set_mode(1'b0, 8'd255);
				stage_open(6);
				stage_bad_type(hrbe_pkg::CH_ZERO);
			end
			END_RECORD: begin
				set_mode(1'b0, 8'd1);
				stage_open(6);
				stage_bad_type(hrbe_pkg::CH_ONE);
			end
			END_SUM: begin
				set_mode(1'b0, 8'd255);
				build_hex_record($urandom_range(0, 4), 16'($urandom_range(0, 65535)), 1'b0);
			end
			default: begin
				set_mode(1'b1, 8'd1);
				build_text_record();
			end
		endcase
		// everything after the stop must be ignored
		for (int k = 0; k < 20; k++) begin
			if (k == 10) stage_end();
			else stage_char(8'($urandom_range(0, 255)));
		end
		release_stage(-1);

		settle();
		repeat (6) @(negedge clk);
		if (fail_cnt == 0 && outcome_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
